@@ hw/rtl/mlif_pkg.sv @@
// Shared types and constants for the multichannel IIR filter.
// Holds the transaction payload structs, request codes and register map.
// No dependencies.
`default_nettype none

package mlif_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned HIST_W = 64;
  localparam int unsigned ACC_W  = 64;
  localparam int unsigned FRAC_W = 15;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned ORDER_REG_W = 4;

  // Request codes carried in req_type.
  localparam logic REQ_COEFF  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // Register index, taken from the word address paddr[2].
  localparam logic REG_FILTER_ORDER = 1'b0;

  typedef struct packed {
    logic               req_type;
    logic [2:0]         tap_index;
    logic signed [31:0] coeff_output_hist;
    logic signed [31:0] coeff_input_hist;
    logic [3:0]         channel;
    logic signed [31:0] sample_value;
    logic               end_of_step;
  } in_t;

  typedef struct packed {
    logic [3:0]         out_channel;
    logic signed [31:0] filtered_value;
  } out_t;

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic clear;
    logic valid;
  } mac_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/mlif_mac.sv @@
// Shared multiply-accumulate unit: two 32x32 signed products per tap, then a
// 64-bit wrapping accumulator. Depends on mlif_pkg.
`default_nettype none

module mlif_mac (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire mlif_pkg::mac_ctrl_t            ctrl_i,
  input  wire logic signed [31:0]             coef_a_i,
  input  wire logic signed [31:0]             hist_y_i,
  input  wire logic signed [31:0]             coef_b_i,
  input  wire logic signed [31:0]             hist_x_i,
  output logic                                busy_o,
  output logic [mlif_pkg::ACC_W-1:0]          acc_o
);

  logic signed [63:0] prod_a_q, prod_b_q;
  logic               prod_valid_q;
  logic [mlif_pkg::ACC_W-1:0] acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
    end else begin
      prod_valid_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_a_q <= coef_a_i * hist_y_i;
    prod_b_q <= coef_b_i * hist_x_i;
    if (ctrl_i.clear) begin
      acc_q <= '0;
    end else if (prod_valid_q) begin
      acc_q <= acc_q + 64'(prod_a_q) + 64'(prod_b_q);
    end
  end

  assign busy_o = prod_valid_q;
  assign acc_o  = acc_q;

endmodule

`default_nettype wire

@@ hw/rtl/mlif_hist.sv @@
// History ring storage for all channels: one write and one registered read
// port, plus a clearing pass after reset. Depends on mlif_pkg.
`default_nettype none

module mlif_hist #(
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        rst_ni,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  rd_addr_i,
  output logic [mlif_pkg::HIST_W-1:0]                      rd_data_o,
  input  wire logic                                        wr_en_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  wr_addr_i,
  input  wire logic [mlif_pkg::HIST_W-1:0]                 wr_data_i,
  output logic                                             clearing_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [mlif_pkg::HIST_W-1:0] mem [DEPTH];
  logic [mlif_pkg::HIST_W-1:0] rd_data_q;
  logic [AW-1:0]               clr_addr_q;
  logic                        clr_active_q;

  logic                        we;
  logic [AW-1:0]               wa;
  logic [mlif_pkg::HIST_W-1:0] wd;

  // The clearing pass owns the write port until every entry holds zero.
  always_comb begin
    if (clr_active_q) begin
      we = 1'b1;
      wa = clr_addr_q;
      wd = '0;
    end else begin
      we = wr_en_i;
      wa = wr_addr_i;
      wd = wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
    end else if (clr_active_q) begin
      if (32'(clr_addr_q) == DEPTH - 1) begin
        clr_active_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o  = rd_data_q;
  assign clearing_o = clr_active_q;

endmodule

`default_nettype wire

@@ hw/rtl/multichannel_lti_iir_filter.sv @@
// Multichannel Direct Form I IIR filter, one shared MAC pair stepped per tap.
// A sample is accepted in idle, then steps one tap per cycle on the shared MAC, drains
// the read and product registers and writes the result, which waits while the output is
// held; in_ready returns after the write. A coefficient is written on acceptance.
// After reset the history memory is cleared one entry a cycle, with in_ready low.
// Depends on mlif_pkg, mlif_mac, mlif_hist.
`default_nettype none

module multichannel_lti_iir_filter #(
  parameter int unsigned MAX_CHANNELS = 16,
  parameter int unsigned MAX_ORDER    = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire mlif_pkg::in_t                 in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output mlif_pkg::out_t                     out_data_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mlif_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int unsigned DEPTH = MAX_CHANNELS * MAX_ORDER;
  localparam int unsigned HAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned PW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int unsigned OW    = $clog2(MAX_ORDER + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_WRITE = 2'd3;

  logic [1:0]                          state_q;
  logic [mlif_pkg::ORDER_REG_W-1:0]    order_q;
  logic [OW-1:0]                       ord_eff;
  logic [PW-1:0]                       ptr_q, ptr_inc;
  logic [PW-1:0]                       k_q, m_q, m_cur;
  logic [HAW-1:0]                      base_q;
  logic [3:0]                          chan_q;
  logic signed [31:0]                  x_q;
  logic                                eos_q;
  logic                                rd_valid_q;
  logic [mlif_pkg::HIST_W-1:0]         coef_mem [MAX_ORDER];
  logic [mlif_pkg::HIST_W-1:0]         coef_rd_q;
  logic [mlif_pkg::HIST_W-1:0]         hist_rd;
  logic                                clearing;
  logic                                mac_busy;
  logic [mlif_pkg::ACC_W-1:0]          acc;
  mlif_pkg::mac_ctrl_t                 mac_ctrl;
  logic signed [31:0]                  y_new;
  logic                                out_valid_q;
  mlif_pkg::out_t                      out_data_q;

  logic in_fire, cfg_wr, is_sample, chan_ok, last_tap, can_out, hist_we;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && (paddr[2] == mlif_pkg::REG_FILTER_ORDER);
  assign prdata  = (paddr[2] == mlif_pkg::REG_FILTER_ORDER) ?
                   32'(order_q) : 32'd0;

  // Order in use: zero acts as one, anything above the maximum saturates.
  always_comb begin
    if (order_q == '0) begin
      ord_eff = OW'(1);
    end else if (32'(order_q) > MAX_ORDER) begin
      ord_eff = OW'(MAX_ORDER);
    end else begin
      ord_eff = OW'(order_q);
    end
  end

  assign ptr_inc   = (32'(ptr_q) + 32'd1 >= 32'(ord_eff)) ? '0 : ptr_q + PW'(1);
  assign m_cur     = (m_q == '0) ? PW'(ord_eff - OW'(1)) : m_q - PW'(1);
  assign last_tap  = (32'(k_q) + 32'd1 == 32'(ord_eff));
  assign in_ready_o = (state_q == ST_IDLE) && !clearing;
  assign in_fire   = in_valid_i && in_ready_o;
  assign is_sample = (in_data_i.req_type == mlif_pkg::REQ_SAMPLE);
  assign chan_ok   = (32'(in_data_i.channel) < MAX_CHANNELS);
  assign can_out   = !out_valid_q || out_ready_i;
  assign hist_we   = (state_q == ST_WRITE) && can_out;
  assign y_new     = $signed(acc[mlif_pkg::FRAC_W +: mlif_pkg::DATA_W]);

  assign mac_ctrl.clear = in_fire && is_sample;
  assign mac_ctrl.valid = rd_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      order_q     <= mlif_pkg::ORDER_REG_W'(1);
      ptr_q       <= '0;
      k_q         <= '0;
      m_q         <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= (state_q == ST_RUN);
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire && is_sample) begin
            if (chan_ok) begin
              k_q     <= '0;
              m_q     <= ptr_q;
              state_q <= ST_RUN;
            end else if (in_data_i.end_of_step) begin
              ptr_q <= ptr_inc;
            end
          end
        end
        ST_RUN: begin
          m_q <= m_cur;
          k_q <= k_q + PW'(1);
          if (last_tap) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!rd_valid_q && !mac_busy) begin
            state_q <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (can_out) begin
            out_valid_q <= 1'b1;
            if (eos_q) begin
              ptr_q <= ptr_inc;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      // Rewriting the order restarts the ring at slot zero.
      if (cfg_wr) begin
        order_q <= pwdata[mlif_pkg::ORDER_REG_W-1:0];
        ptr_q   <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && is_sample) begin
      base_q <= HAW'(32'(in_data_i.channel) * MAX_ORDER);
      chan_q <= in_data_i.channel;
      x_q    <= in_data_i.sample_value;
      eos_q  <= in_data_i.end_of_step;
    end
    if (hist_we) begin
      out_data_q.out_channel    <= chan_q;
      out_data_q.filtered_value <= y_new;
    end
  end

  // Coefficient table: taps beyond the table depth are dropped.
  always_ff @(posedge clk_i) begin
    if (in_fire && !is_sample && (32'(in_data_i.tap_index) < MAX_ORDER)) begin
      coef_mem[PW'(in_data_i.tap_index)] <= {in_data_i.coeff_output_hist,
                                             in_data_i.coeff_input_hist};
    end
    coef_rd_q <= coef_mem[k_q];
  end

  mlif_hist #(
    .DEPTH (DEPTH)
  ) u_hist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_addr_i  (base_q + HAW'(m_cur)),
    .rd_data_o  (hist_rd),
    .wr_en_i    (hist_we),
    .wr_addr_i  (base_q + HAW'(ptr_q)),
    .wr_data_i  ({x_q, y_new}),
    .clearing_o (clearing)
  );

  // Memory words hold {a, b} for coefficients and {x, y} for history.
  mlif_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .coef_a_i ($signed(coef_rd_q[63:32])),
    .hist_y_i ($signed(hist_rd[31:0])),
    .coef_b_i ($signed(coef_rd_q[31:0])),
    .hist_x_i ($signed(hist_rd[63:32])),
    .busy_o   (mac_busy),
    .acc_o    (acc)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire
